### rtl/core/bleadv_pkg.sv
// Shared types and constants of the advertising data field extractor.
package bleadv_pkg;

  localparam int unsigned MaxPayload = 62;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [7:0] AdTypeNameShort = 8'h08;
  localparam logic [7:0] AdTypeNameFull  = 8'h09;
  localparam logic [7:0] AdTypeMfg       = 8'hFF;
  localparam logic [7:0] AdTypeUuid16Inc = 8'h02;
  localparam logic [7:0] AdTypeUuid16Cmp = 8'h03;
  localparam logic [7:0] AdTypeTxPower   = 8'h0A;
  localparam logic [7:0] AdTypeAppear    = 8'h19;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_MFG     = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  // What the back end has to do with one queued byte.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_NAME    = 3'd1,
    OP_MFG     = 3'd2,
    OP_UUID_LO = 3'd3,
    OP_UUID_HI = 3'd4,
    OP_TX      = 3'd5,
    OP_APP_LO  = 3'd6,
    OP_APP_HI  = 3'd7
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       rec_start;
    logic       rec_end;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic        has_name;
    logic        has_mfg;
    logic        has_uuid;
    logic        has_tx;
    logic        has_app;
    logic [7:0]  first_byte;
    logic [15:0] uuid;
    logic [7:0]  tx;
    logic [15:0] app;
  } capture_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        record_start;
    logic        has_name;
    logic        has_mfg;
    logic        has_uuid;
    logic [15:0] uuid;
    logic        has_tx;
    logic [7:0]  tx;
    logic        has_app;
    logic [15:0] app;
    logic        final_res;
  } result_t;

endpackage

### rtl/core/bleadv_front.sv
// Front end: walks the length-type-value structures and classifies each byte.
module bleadv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic [5:0]          packet_length_i,
  input  logic                last_byte_i,
  output logic                push_o,
  output bleadv_pkg::entry_t  entry_o
);
  import bleadv_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN   = 3'b001,
    PH_TYPE  = 3'b010,
    PH_VALUE = 3'b100
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [5:0] pos_q, pos_d;
  logic [5:0] left_q, left_d;
  logic [7:0] type_q, type_d;
  logic [1:0] vidx_q, vidx_d;
  logic       stopped_q, stopped_d;
  logic       name_found_q, name_found_d;
  logic       uuid_found_q, uuid_found_d;

  logic [5:0] len;
  logic       active;
  logic [8:0] end_pos;
  logic [5:0] left_dec;
  op_e        op;

  always_comb begin
    len = (packet_length_i > 6'(MaxPayload)) ? 6'(MaxPayload) : packet_length_i;
    active = !stopped_q && (pos_q < len);
    end_pos = 9'(pos_q) + 9'd1 + 9'(data_byte_i);
    left_dec = left_q - 6'd1;

    phase_d = phase_q;
    pos_d = (pos_q == 6'h3F) ? pos_q : pos_q + 6'd1;
    left_d = left_q;
    type_d = type_q;
    vidx_d = vidx_q;
    stopped_d = stopped_q;
    name_found_d = name_found_q;
    uuid_found_d = uuid_found_q;
    op = OP_NONE;

    if (active) begin
      unique case (phase_q)
        PH_LEN: begin
          if (9'(pos_q) + 9'd1 < 9'(len)) begin
            if (data_byte_i == 8'd0 || end_pos > 9'(len)) begin
              stopped_d = 1'b1;
            end else begin
              // The overrun check bounds the length below the packet length.
              left_d = data_byte_i[5:0];
              phase_d = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          type_d = data_byte_i;
          left_d = left_dec;
          vidx_d = 2'd0;
          phase_d = (left_dec != 6'd0) ? PH_VALUE : PH_LEN;
        end
        PH_VALUE: begin
          if ((type_q == AdTypeNameShort || type_q == AdTypeNameFull) && !name_found_q) begin
            op = OP_NAME;
            if (left_q == 6'd1) name_found_d = 1'b1;
          end else if (type_q == AdTypeMfg) begin
            op = OP_MFG;
          end else if ((type_q == AdTypeUuid16Inc || type_q == AdTypeUuid16Cmp) &&
                       !uuid_found_q) begin
            if (vidx_q == 2'd0) begin
              op = OP_UUID_LO;
            end else if (vidx_q == 2'd1) begin
              op = OP_UUID_HI;
              uuid_found_d = 1'b1;
            end
          end else if (type_q == AdTypeTxPower) begin
            if (vidx_q == 2'd0) op = OP_TX;
          end else if (type_q == AdTypeAppear) begin
            if (vidx_q == 2'd0) op = OP_APP_LO;
            else if (vidx_q == 2'd1) op = OP_APP_HI;
          end
          // Only the first two value bytes matter, so the index saturates at two.
          vidx_d = (vidx_q == 2'd2) ? vidx_q : vidx_q + 2'd1;
          left_d = left_dec;
          if (left_dec == 6'd0) phase_d = PH_LEN;
        end
        default: phase_d = PH_LEN;
      endcase
    end

    if (last_byte_i) begin
      phase_d = PH_LEN;
      pos_d = '0;
      left_d = '0;
      type_d = '0;
      vidx_d = '0;
      stopped_d = 1'b0;
      name_found_d = 1'b0;
      uuid_found_d = 1'b0;
    end

    entry_o.op = op;
    entry_o.data = data_byte_i;
    entry_o.rec_start = (vidx_q == 2'd0);
    entry_o.rec_end = (left_q == 6'd1);
    entry_o.last = last_byte_i;
    push_o = accept_i && (op != OP_NONE || last_byte_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      pos_q <= '0;
      left_q <= '0;
      type_q <= '0;
      vidx_q <= '0;
      stopped_q <= 1'b0;
      name_found_q <= 1'b0;
      uuid_found_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q <= pos_d;
      left_q <= left_d;
      type_q <= type_d;
      vidx_q <= vidx_d;
      stopped_q <= stopped_d;
      name_found_q <= name_found_d;
      uuid_found_q <= uuid_found_d;
    end
  end

endmodule

### rtl/core/bleadv_fifo.sv
// Short queue of classified bytes between the front and back ends.
module bleadv_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bleadv_pkg::entry_t push_data_i,
  input  logic               pop_i,
  output bleadv_pkg::entry_t head_o,
  output logic               empty_o,
  output logic               full_o
);
  import bleadv_pkg::*;

  entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign head_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

### rtl/core/bleadv_back.sv
// Back end: applies captures and drives the registered result word.
module bleadv_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bleadv_pkg::entry_t  head_i,
  input  logic                head_valid_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bleadv_pkg::result_t out_o
);
  import bleadv_pkg::*;

  capture_t cap_q, cap_d;
  result_t  out_q, out_d, byte_res, sum_res;
  logic     out_valid_q, out_valid_d;
  logic     sub_q, sub_d;
  logic     need_byte, need_sum, load_ok;

  always_comb begin
    cap_d = cap_q;
    case (head_i.op)
      OP_NAME: if (head_i.rec_end) cap_d.has_name = 1'b1;
      OP_MFG: cap_d.has_mfg = 1'b1;
      OP_UUID_LO: cap_d.first_byte = head_i.data;
      OP_UUID_HI: begin
        cap_d.uuid = {head_i.data, cap_q.first_byte};
        cap_d.has_uuid = 1'b1;
      end
      OP_TX: begin
        cap_d.tx = head_i.data;
        cap_d.has_tx = 1'b1;
      end
      OP_APP_LO: cap_d.first_byte = head_i.data;
      OP_APP_HI: begin
        cap_d.app = {head_i.data, cap_q.first_byte};
        cap_d.has_app = 1'b1;
      end
      default: ;
    endcase

    byte_res = '0;
    byte_res.kind = (head_i.op == OP_NAME) ? KIND_NAME : KIND_MFG;
    byte_res.data = head_i.data;
    byte_res.record_start = head_i.rec_start;

    // The summary includes what this same word captured.
    sum_res = '0;
    sum_res.kind = KIND_SUMMARY;
    sum_res.has_name = cap_d.has_name;
    sum_res.has_mfg = cap_d.has_mfg;
    sum_res.has_uuid = cap_d.has_uuid;
    sum_res.uuid = cap_d.uuid;
    sum_res.has_tx = cap_d.has_tx;
    sum_res.tx = cap_d.tx;
    sum_res.has_app = cap_d.has_app;
    sum_res.app = cap_d.app;
    sum_res.final_res = 1'b1;

    need_byte = (head_i.op == OP_NAME) || (head_i.op == OP_MFG);
    need_sum = head_i.last;
    load_ok = !out_valid_q || !out_stall_i;

    pop_o = 1'b0;
    out_d = out_q;
    sub_d = sub_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (head_valid_i) begin
      if (need_byte && !sub_q) begin
        if (load_ok) begin
          out_d = byte_res;
          out_valid_d = 1'b1;
          if (need_sum) sub_d = 1'b1;
          else pop_o = 1'b1;
        end
      end else if (need_sum) begin
        if (load_ok) begin
          out_d = sum_res;
          out_valid_d = 1'b1;
          sub_d = 1'b0;
          pop_o = 1'b1;
        end
      end else begin
        pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
      out_valid_q <= 1'b0;
      sub_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q <= sub_d;
      if (pop_o) cap_q <= head_i.last ? '0 : cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

endmodule

### rtl/core/ble_adv_data_field_extractor.sv
// Top level: front end, word queue and back end of the advertising data parser.
// A result word is registered in the word queue and then in the back end's output register.
// Throughput: one byte per cycle while the queue is not full; a final packet byte that is
// itself a name or manufacturer value byte yields two words and holds the back end for both,
// absorbed by the four-word queue. Reset is asynchronous and clears all parse and capture state.
module ble_adv_data_field_extractor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic [5:0]        packet_length_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        out_byte_o,
  output logic              record_start_o,
  output logic              has_name_o,
  output logic              has_mfg_o,
  output logic              has_uuid_o,
  output logic [15:0]       service_uuid_o,
  output logic              has_tx_power_o,
  output logic signed [7:0] tx_power_o,
  output logic              has_appearance_o,
  output logic [15:0]       appearance_o,
  output logic              final_res_o
);
  import bleadv_pkg::*;

  entry_t  push_entry, head;
  logic    push, pop, empty, full, accept;
  result_t res;

  assign in_stall_o = full;
  assign accept = in_valid_i && !full;

  bleadv_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .packet_length_i (packet_length_i),
    .last_byte_i     (last_byte_i),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  bleadv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  bleadv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (res)
  );

  assign kind_o = res.kind;
  assign out_byte_o = res.data;
  assign record_start_o = res.record_start;
  assign has_name_o = res.has_name;
  assign has_mfg_o = res.has_mfg;
  assign has_uuid_o = res.has_uuid;
  assign service_uuid_o = res.uuid;
  assign has_tx_power_o = res.has_tx;
  assign tx_power_o = $signed(res.tx);
  assign has_appearance_o = res.has_app;
  assign appearance_o = res.app;
  assign final_res_o = res.final_res;

endmodule

### rtl/core/bleadv_checker.sv
// Port-level checks of the advertising data parser, bound to its top level.
module bleadv_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        kind_o,
  input logic [7:0]        out_byte_o,
  input logic              record_start_o,
  input logic              has_name_o,
  input logic              has_mfg_o,
  input logic              has_uuid_o,
  input logic [15:0]       service_uuid_o,
  input logic              has_tx_power_o,
  input logic signed [7:0] tx_power_o,
  input logic              has_appearance_o,
  input logic [15:0]       appearance_o,
  input logic              final_res_o
);
  import bleadv_pkg::*;

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
    $stable(out_byte_o) && $stable(final_res_o) && $stable(service_uuid_o))
    else $error("stalled result word changed");

  // The final flag goes with the summary kind and nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (final_res_o == (kind_o == KIND_SUMMARY)))
    else $error("final flag and kind disagree");

  // Byte words carry no summary content.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !final_res_o |-> !has_name_o && !has_mfg_o && !has_uuid_o &&
    !has_tx_power_o && !has_appearance_o && service_uuid_o == 16'd0 &&
    tx_power_o == 8'sd0 && appearance_o == 16'd0)
    else $error("summary field set in a byte word");

  // A summary carries no byte and no record start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_res_o |-> out_byte_o == 8'd0 && !record_start_o)
    else $error("summary word carries a byte");

  // Captured values stay zero unless their flag is set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_res_o |-> (has_uuid_o || service_uuid_o == 16'd0) &&
    (has_tx_power_o || tx_power_o == 8'sd0) && (has_appearance_o || appearance_o == 16'd0))
    else $error("summary value without its flag");

endmodule

bind ble_adv_data_field_extractor bleadv_checker u_bleadv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kind_o           (kind_o),
  .out_byte_o       (out_byte_o),
  .record_start_o   (record_start_o),
  .has_name_o       (has_name_o),
  .has_mfg_o        (has_mfg_o),
  .has_uuid_o       (has_uuid_o),
  .service_uuid_o   (service_uuid_o),
  .has_tx_power_o   (has_tx_power_o),
  .tx_power_o       (tx_power_o),
  .has_appearance_o (has_appearance_o),
  .appearance_o     (appearance_o),
  .final_res_o      (final_res_o)
);

### sim/tb_ble_adv_data_field_extractor.sv
// Testbench for the advertising data field extractor: directed and random payloads checked against a predictor.
module tb_ble_adv_data_field_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  import bleadv_pkg::*;

  localparam int unsigned StallLimit = 2000;

  typedef enum logic [1:0] {
    EXPECT_LEN,
    EXPECT_TYPE,
    IN_VALUE
  } parse_phase_e;

  typedef struct {
    logic [7:0] data;
    logic [5:0] len;
    logic       last;
  } adv_byte_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        data_byte_i = '0;
  logic [5:0]        packet_length_i = '0;
  logic              last_byte_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        kind_o;
  logic [7:0]        out_byte_o;
  logic              record_start_o;
  logic              has_name_o;
  logic              has_mfg_o;
  logic              has_uuid_o;
  logic [15:0]       service_uuid_o;
  logic              has_tx_power_o;
  logic signed [7:0] tx_power_o;
  logic              has_appearance_o;
  logic [15:0]       appearance_o;
  logic              final_res_o;

  adv_byte_t  payload_bytes[$];
  logic [7:0] pkt_bytes[$];
  result_t    parsed_words[$];
  adv_byte_t  drv_byte;
  int         bytes_queued = 0;
  int         fail_count = 0;
  int         quiet_cycles = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;

  // Parser state as the block should hold it.
  parse_phase_e prs_phase;
  logic [7:0]   prs_pos;
  logic [7:0]   prs_left;
  logic [7:0]   prs_type;
  logic [7:0]   prs_vidx;
  logic [7:0]   prs_lo_byte;
  logic         prs_halted;
  logic         got_name, got_mfg, got_uuid, got_tx, got_app;
  logic [15:0]  cap_uuid;
  logic [7:0]   cap_tx;
  logic [15:0]  cap_app;

  ble_adv_data_field_extractor i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .packet_length_i  (packet_length_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .out_byte_o       (out_byte_o),
    .record_start_o   (record_start_o),
    .has_name_o       (has_name_o),
    .has_mfg_o        (has_mfg_o),
    .has_uuid_o       (has_uuid_o),
    .service_uuid_o   (service_uuid_o),
    .has_tx_power_o   (has_tx_power_o),
    .tx_power_o       (tx_power_o),
    .has_appearance_o (has_appearance_o),
    .appearance_o     (appearance_o),
    .final_res_o      (final_res_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic clear_parser();
    prs_phase   = EXPECT_LEN;
    prs_pos     = '0;
    prs_left    = '0;
    prs_type    = '0;
    prs_vidx    = '0;
    prs_lo_byte = '0;
    prs_halted  = 1'b0;
    got_name    = 1'b0;
    got_mfg     = 1'b0;
    got_uuid    = 1'b0;
    got_tx      = 1'b0;
    got_app     = 1'b0;
    cap_uuid    = '0;
    cap_tx      = '0;
    cap_app     = '0;
  endtask

  // Advances the parser by one payload byte and queues the words it should produce.
  task automatic parse_payload_byte(input logic [7:0] b, input logic [5:0] len_field,
                                    input logic is_last);
    result_t     word;
    int unsigned eff_len;
    int unsigned pos;
    eff_len = (len_field > MaxPayload) ? MaxPayload : len_field;
    pos     = prs_pos;
    if (!prs_halted && pos < eff_len) begin
      case (prs_phase)
        EXPECT_LEN: begin
          // A length byte with no room for a type after it is dropped.
          if (pos + 1 < eff_len) begin
            if (b == 8'd0 || pos + 1 + b > eff_len) begin
              prs_halted = 1'b1;
            end else begin
              prs_left  = b;
              prs_phase = EXPECT_TYPE;
            end
          end
        end
        EXPECT_TYPE: begin
          prs_type  = b;
          prs_left  = prs_left - 8'd1;
          prs_vidx  = '0;
          prs_phase = (prs_left != 8'd0) ? IN_VALUE : EXPECT_LEN;
        end
        default: begin
          word = '0;
          if ((prs_type == AdTypeNameShort || prs_type == AdTypeNameFull) && !got_name) begin
            word.kind         = KIND_NAME;
            word.data         = b;
            word.record_start = (prs_vidx == 8'd0);
            parsed_words.insert(parsed_words.size(), word);
            if (prs_left == 8'd1) got_name = 1'b1;
          end else if (prs_type == AdTypeMfg) begin
            word.kind         = KIND_MFG;
            word.data         = b;
            word.record_start = (prs_vidx == 8'd0);
            parsed_words.insert(parsed_words.size(), word);
            got_mfg = 1'b1;
          end else if ((prs_type == AdTypeUuid16Inc || prs_type == AdTypeUuid16Cmp) &&
                       !got_uuid) begin
            if (prs_vidx == 8'd0) begin
              prs_lo_byte = b;
            end else if (prs_vidx == 8'd1) begin
              cap_uuid = {b, prs_lo_byte};
              got_uuid = 1'b1;
            end
          end else if (prs_type == AdTypeTxPower) begin
            if (prs_vidx == 8'd0) begin
              cap_tx = b;
              got_tx = 1'b1;
            end
          end else if (prs_type == AdTypeAppear) begin
            if (prs_vidx == 8'd0) begin
              prs_lo_byte = b;
            end else if (prs_vidx == 8'd1) begin
              cap_app = {b, prs_lo_byte};
              got_app = 1'b1;
            end
          end
          if (prs_vidx != 8'hFF) prs_vidx = prs_vidx + 8'd1;
          prs_left = prs_left - 8'd1;
          if (prs_left == 8'd0) prs_phase = EXPECT_LEN;
        end
      endcase
    end
    if (prs_pos != 8'hFF) prs_pos = prs_pos + 8'd1;
    if (is_last) begin
      word           = '0;
      word.kind      = KIND_SUMMARY;
      word.has_name  = got_name;
      word.has_mfg   = got_mfg;
      word.has_uuid  = got_uuid;
      word.uuid      = cap_uuid;
      word.has_tx    = got_tx;
      word.tx        = cap_tx;
      word.has_app   = got_app;
      word.app       = cap_app;
      word.final_res = 1'b1;
      parsed_words.insert(parsed_words.size(), word);
      clear_parser();
    end
  endtask

  function automatic string fmt_word(input result_t w);
    return $sformatf(
        "kind=%0d byte=%02h start=%0b name=%0b mfg=%0b uuid=%0b/%04h tx=%0b/%0d app=%0b/%04h end=%0b",
        w.kind, w.data, w.record_start, w.has_name, w.has_mfg, w.has_uuid, w.uuid,
        w.has_tx, $signed(w.tx), w.has_app, w.app, w.final_res);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Moves the packet in pkt_bytes onto the send queue; bytes from switch_at on carry len_b.
  task automatic queue_packet(input logic [5:0] len_a, input logic [5:0] len_b,
                              input int switch_at);
    adv_byte_t item;
    int        n;
    n = pkt_bytes.size();
    for (int i = 0; i < n; i++) begin
      item.data = pkt_bytes[i];
      item.len  = (i >= switch_at) ? len_b : len_a;
      item.last = (i == n - 1);
      payload_bytes.insert(payload_bytes.size(), item);
    end
    bytes_queued += n;
    pkt_bytes.delete();
  endtask

  task automatic add_random_packet();
    int         len_at[$];
    int         n_len, room, vlen, vmax, r, sel, k, switch_at;
    logic [7:0] lb;
    logic [5:0] len_a, len_b;
    r = $urandom_range(0, 99);
    n_len = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 62) : $urandom_range(1, 31);
    len_a = 6'(n_len);
    if (n_len == 62 && $urandom_range(0, 1) == 1) len_a = 6'd63;
    len_b = len_a;
    switch_at = 1000;
    if (r >= 90) begin
      // Pure noise: random bytes under a random length.
      len_a = 6'($urandom_range(0, 63));
      len_b = len_a;
      k = $urandom_range(1, 40);
      for (int i = 0; i < k; i++) begin
        lb = 8'($urandom_range(0, 255));
        pkt_bytes.insert(pkt_bytes.size(), lb);
      end
    end else begin
      room = n_len;
      while (room >= 2) begin
        vmax = room - 2;
        if ($urandom_range(0, 3) == 0) vlen = $urandom_range(0, vmax);
        else vlen = $urandom_range(0, (vmax < 4) ? vmax : 4);
        len_at.insert(len_at.size(), pkt_bytes.size());
        lb = 8'(vlen + 1);
        pkt_bytes.insert(pkt_bytes.size(), lb);
        case ($urandom_range(0, 8))
          0: lb = AdTypeNameShort;
          1: lb = AdTypeNameFull;
          2: lb = AdTypeMfg;
          3: lb = AdTypeUuid16Inc;
          4: lb = AdTypeUuid16Cmp;
          5: lb = AdTypeTxPower;
          6: lb = AdTypeAppear;
          default: lb = 8'($urandom_range(0, 255));
        endcase
        pkt_bytes.insert(pkt_bytes.size(), lb);
        for (int i = 0; i < vlen; i++) begin
          lb = 8'($urandom_range(0, 255));
          pkt_bytes.insert(pkt_bytes.size(), lb);
        end
        room -= vlen + 2;
        if ($urandom_range(0, 19) == 0) break;
      end
      // Leftover room: padding, a stray length byte, or junk.
      while (room > 0) begin
        lb = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        pkt_bytes.insert(pkt_bytes.size(), lb);
        room--;
      end
      if (r >= 75) begin
        sel = $urandom_range(0, 4);
        if ((sel == 0 || sel == 1) && len_at.size() == 0) sel = 2;
        case (sel)
          0: begin
            k = len_at[$urandom_range(0, len_at.size() - 1)];
            pkt_bytes[k] = pkt_bytes[k] + 8'($urandom_range(1, 8));
          end
          1: pkt_bytes[len_at[$urandom_range(0, len_at.size() - 1)]] = 8'd0;
          2: begin
            k = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > k) void'(pkt_bytes.pop_back());
          end
          3: begin
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++) begin
              lb = 8'($urandom_range(0, 255));
              pkt_bytes.insert(pkt_bytes.size(), lb);
            end
          end
          default: begin
            switch_at = $urandom_range(0, pkt_bytes.size() - 1);
            len_b = 6'($urandom_range(0, 63));
          end
        endcase
      end
    end
    queue_packet(len_a, len_b, switch_at);
  endtask

  // Sender: a word stays on the inputs until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      data_byte_i     <= '0;
      packet_length_i <= '0;
      last_byte_i     <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_payload_byte(data_byte_i, packet_length_i, last_byte_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (payload_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          drv_byte = payload_bytes.pop_front();
          in_valid_i      <= 1'b1;
          data_byte_i     <= drv_byte.data;
          packet_length_i <= drv_byte.len;
          last_byte_i     <= drv_byte.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each taken word against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen.kind         = kind_e'(kind_o);
        seen.data         = out_byte_o;
        seen.record_start = record_start_o;
        seen.has_name     = has_name_o;
        seen.has_mfg      = has_mfg_o;
        seen.has_uuid     = has_uuid_o;
        seen.uuid         = service_uuid_o;
        seen.has_tx       = has_tx_power_o;
        seen.tx           = tx_power_o;
        seen.has_app      = has_appearance_o;
        seen.app          = appearance_o;
        seen.final_res    = final_res_o;
        if (parsed_words.size() == 0) begin
          note_failure($sformatf("unexpected word %s", fmt_word(seen)));
        end else begin
          want = parsed_words.pop_front();
          if (seen !== want) begin
            note_failure($sformatf("expected %s, got %s", fmt_word(want), fmt_word(seen)));
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: ends the run when work is outstanding but nothing moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else if (payload_bytes.size() != 0 || in_valid_i || parsed_words.size() != 0) begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    clear_parser();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Name with an empty structure, TX power at its minimum, a UUID, a manufacturer
    // byte and a length byte in the last position.
    pkt_bytes = '{8'h03, 8'h09, 8'h41, 8'h42, 8'h01, 8'hAA, 8'h02, 8'h0A, 8'h80,
                  8'h03, 8'h03, 8'hCD, 8'hAB, 8'h02, 8'hFF, 8'hEE, 8'h05};
    queue_packet(6'd17, 6'd17, 1000);
    // Oversized length field, appearance, then a zero length stops the walk.
    pkt_bytes = '{8'h03, 8'h19, 8'hFF, 8'hFF, 8'h00, 8'h55};
    queue_packet(6'd63, 6'd63, 1000);
    // Overrun on the first structure, then a byte past the length.
    pkt_bytes = '{8'h02, 8'h09, 8'h77};
    queue_packet(6'd2, 6'd2, 1000);
    // Zero packet length still ends with a summary.
    pkt_bytes = '{8'h42};
    queue_packet(6'd0, 6'd0, 1000);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      while (bytes_queued < 27 + (ph + 1) * 431) add_random_packet();
      while (payload_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    end

    while (parsed_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && parsed_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
